// ===== sv/clw_pkg.sv =====
package clw_pkg;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_INST = 2'd1,
        CMD_DATA = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_PULSE    = 2'd0,
        REG_BUSY     = 2'd1,
        REG_BYTEWAIT = 2'd2,
        REG_POWERON  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        HS_POWER           = 3'd0,
        HS_PULSE           = 3'd1,
        HS_PULSE_BUSY      = 3'd2,
        HS_PULSE_WAIT      = 3'd3,
        HS_PULSE_WAIT_BUSY = 3'd4
    } t_hold_sel;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned HOLD_W = 18;
    localparam int unsigned STEP_W = 5;

    localparam logic [TICK_W-1:0] PULSE_RST    = 16'd200;
    localparam logic [TICK_W-1:0] BUSY_RST     = 16'd10000;
    localparam logic [TICK_W-1:0] BYTEWAIT_RST = 16'd16000;
    localparam logic [TICK_W-1:0] POWERON_RST  = 16'd50000;

    // init: idle state, four wake-up nibbles (8 phases), four bytes (16 phases)
    localparam logic [STEP_W-1:0] INIT_LAST_STEP   = 5'd24;
    localparam logic [STEP_W-1:0] INIT_NIB_LAST    = 5'd8;
    localparam logic [STEP_W-1:0] INIT_BYTE_FIRST  = 5'd9;
    localparam logic [1:0]        BYTE_LAST_PHASE  = 2'd3;
    localparam logic [1:0]        INIT_LAST_BYTE   = 2'd3;
    localparam logic [1:0]        WAKE_LAST_NIB    = 2'd3;
    localparam logic [3:0]        WAKE_NIB         = 4'h3;
    localparam logic [3:0]        MODE4_NIB        = 4'h2;

    // element 0 is the first byte sent
    localparam logic [3:0][7:0] INIT_BYTES = {8'h01, 8'h06, 8'h0C, 8'h28};

    typedef struct packed {
        logic      valid;
        logic      rs;
        logic [3:0] nibble;
        logic      enable;
        t_hold_sel hold_sel;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        logic space;
    } t_dp_stat;

endpackage

// ===== sv/clw_in_if.sv =====
interface clw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== sv/clw_out_if.sv =====
interface clw_out_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  nibble;
    logic        enable;
    logic [17:0] hold_ticks;
    logic        last;

    modport source (output valid, output reg_select, output nibble, output enable,
                    output hold_ticks, output last, input ready);
    modport sink   (input valid, input reg_select, input nibble, input enable,
                    input hold_ticks, input last, output ready);
endinterface

// ===== sv/clw_ctrl.sv =====
module clw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_cmd,
    input  logic [7:0]          i_in_value,
    output logic                o_in_ready,
    input  clw_pkg::t_dp_stat   i_stat,
    output clw_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_INIT = 3'b010,
        ST_BYTE = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [clw_pkg::STEP_W-1:0]   r_step, n_step;
    logic [7:0]                   r_byte, n_byte;
    logic                         r_rs, n_rs;

    logic                         issue;
    logic                         is_last;
    logic [clw_pkg::STEP_W-1:0]   s_nib;
    logic [clw_pkg::STEP_W-1:0]   s_byte;
    logic [1:0]                   phase;
    logic [1:0]                   byte_sel;
    logic [7:0]                   cur_byte;

    assign o_in_ready = (r_state == ST_IDLE);
    assign issue      = o_cmd.valid && i_stat.space;

    assign s_nib  = r_step - 5'd1;
    assign s_byte = r_step - clw_pkg::INIT_BYTE_FIRST;

    always_comb begin
        o_cmd          = '0;
        o_cmd.hold_sel = clw_pkg::HS_PULSE;
        phase          = r_step[1:0];
        byte_sel       = 2'd0;
        cur_byte       = r_byte;
        is_last        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.valid = 1'b0;
            end
            ST_INIT: begin
                o_cmd.valid = 1'b1;
                o_cmd.rs    = 1'b0;
                is_last     = (r_step == clw_pkg::INIT_LAST_STEP);
                if (r_step == '0) begin
                    o_cmd.hold_sel = clw_pkg::HS_POWER;
                end else if (r_step <= clw_pkg::INIT_NIB_LAST) begin
                    o_cmd.nibble = (s_nib[2:1] == clw_pkg::WAKE_LAST_NIB)
                                   ? clw_pkg::MODE4_NIB : clw_pkg::WAKE_NIB;
                    o_cmd.enable   = ~s_nib[0];
                    o_cmd.hold_sel = s_nib[0] ? clw_pkg::HS_PULSE_BUSY
                                              : clw_pkg::HS_PULSE;
                end else begin
                    byte_sel     = s_byte[3:2];
                    phase        = s_byte[1:0];
                    cur_byte     = clw_pkg::INIT_BYTES[byte_sel];
                    o_cmd.nibble = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
                    o_cmd.enable = ~phase[0];
                    if (phase == clw_pkg::BYTE_LAST_PHASE) begin
                        o_cmd.hold_sel = (byte_sel == clw_pkg::INIT_LAST_BYTE)
                                         ? clw_pkg::HS_PULSE_WAIT_BUSY
                                         : clw_pkg::HS_PULSE_WAIT;
                    end
                end
            end
            ST_BYTE: begin
                o_cmd.valid  = 1'b1;
                o_cmd.rs     = r_rs;
                o_cmd.nibble = phase[1] ? r_byte[3:0] : r_byte[7:4];
                o_cmd.enable = ~phase[0];
                is_last      = (phase == clw_pkg::BYTE_LAST_PHASE);
                if (is_last) begin
                    o_cmd.hold_sel = clw_pkg::HS_PULSE_WAIT;
                end
            end
            default: begin
                o_cmd.valid = 1'b0;
            end
        endcase
        o_cmd.last = is_last;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_byte  = r_byte;
        n_rs    = r_rs;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_step = '0;
                    n_byte = i_in_value;
                    n_rs   = (i_in_cmd == clw_pkg::CMD_DATA);
                    case (i_in_cmd)
                        clw_pkg::CMD_INIT: n_state = ST_INIT;
                        clw_pkg::CMD_INST,
                        clw_pkg::CMD_DATA: n_state = ST_BYTE;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INIT, ST_BYTE: begin
                if (issue) begin
                    n_step = r_step + 5'd1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_byte <= n_byte;
        r_rs   <= n_rs;
    end

endmodule

// ===== sv/clw_dp.sv =====
module clw_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [clw_pkg::TICK_W-1:0]  i_cfg_data,
    input  clw_pkg::t_dp_cmd            i_cmd,
    output clw_pkg::t_dp_stat           o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_out_rs,
    output logic [3:0]                  o_out_nibble,
    output logic                        o_out_enable,
    output logic [clw_pkg::HOLD_W-1:0]  o_out_hold,
    output logic                        o_out_last
);

    logic [clw_pkg::TICK_W-1:0] r_pulse, r_busy, r_wait, r_power;
    logic                       r_valid;
    logic                       r_rs;
    logic [3:0]                 r_nibble;
    logic                       r_enable;
    logic [clw_pkg::HOLD_W-1:0] r_hold, n_hold;
    logic                       r_last;
    logic                       load;
    logic [clw_pkg::HOLD_W-1:0] pulse_x, busy_x, wait_x;

    assign o_stat.space = !r_valid || i_out_ready;
    assign load         = i_cmd.valid && o_stat.space;

    assign pulse_x = {2'b00, r_pulse};
    assign busy_x  = {2'b00, r_busy};
    assign wait_x  = {2'b00, r_wait};

    always_comb begin
        case (i_cmd.hold_sel)
            clw_pkg::HS_POWER:           n_hold = {2'b00, r_power};
            clw_pkg::HS_PULSE:           n_hold = pulse_x;
            clw_pkg::HS_PULSE_BUSY:      n_hold = pulse_x + busy_x;
            clw_pkg::HS_PULSE_WAIT:      n_hold = pulse_x + wait_x;
            clw_pkg::HS_PULSE_WAIT_BUSY: n_hold = pulse_x + wait_x + busy_x;
            default:                     n_hold = pulse_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse <= clw_pkg::PULSE_RST;
            r_busy  <= clw_pkg::BUSY_RST;
            r_wait  <= clw_pkg::BYTEWAIT_RST;
            r_power <= clw_pkg::POWERON_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clw_pkg::REG_PULSE:    r_pulse <= i_cfg_data;
                clw_pkg::REG_BUSY:     r_busy  <= i_cfg_data;
                clw_pkg::REG_BYTEWAIT: r_wait  <= i_cfg_data;
                clw_pkg::REG_POWERON:  r_power <= i_cfg_data;
                default:               r_pulse <= r_pulse;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (load) begin
            r_rs     <= i_cmd.rs;
            r_nibble <= i_cmd.nibble;
            r_enable <= i_cmd.enable;
            r_hold   <= n_hold;
            r_last   <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_rs     = r_rs;
    assign o_out_nibble = r_nibble;
    assign o_out_enable = r_enable;
    assign o_out_hold   = r_hold;
    assign o_out_last   = r_last;

endmodule

// ===== sv/char_lcd_4bit_writer_core.sv =====
// The request is captured into the step sequencer, which then loads the first pin state
// into the output register; the sequencer moves one pin state per cycle into that register
// while it has space; a byte request gives 4 states, init gives 25 states.
// A new request is taken once the sequencer has issued the last state of the previous one.
// Reset (synchronous, active low): sequencer idle, output empty, timing registers
// back to 200 / 10000 / 16000 / 50000 ticks.
module char_lcd_4bit_writer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    clw_in_if.sink      i_in,
    clw_out_if.source   o_out
);

    clw_pkg::t_dp_cmd  cmd;
    clw_pkg::t_dp_stat stat;

    clw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_in_value (i_in.value),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    clw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_rs     (o_out.reg_select),
        .o_out_nibble (o_out.nibble),
        .o_out_enable (o_out.enable),
        .o_out_hold   (o_out.hold_ticks),
        .o_out_last   (o_out.last)
    );

endmodule

// ===== test/char_lcd_4bit_writer_core_test.sv =====
module char_lcd_4bit_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // HD44780 wake-up and setup codes
    localparam logic [3:0] LCD_WAKE_NIB    = 4'h3;
    localparam logic [3:0] LCD_MODE4_NIB   = 4'h2;
    localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam int         REPORT_LIMIT    = 10;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         RETUNE_INTERVAL = 60;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic        enable;
        logic [17:0] hold;
        logic        last;
    } t_pin_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    clw_in_if  req_if ();
    clw_out_if pin_if ();

    char_lcd_4bit_writer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (pin_if)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the timing registers
    logic [15:0] pulse_ticks;
    logic [15:0] busy_ticks;
    logic [15:0] byte_wait_ticks;
    logic [15:0] power_on_ticks;

    t_pin_state expected_pins[$];
    int         mismatch_count;
    int         src_idle_pct;
    int         snk_idle_pct;

    function automatic void push_pin_state(input logic rs, input logic [3:0] nib,
                                           input logic en, input int unsigned hold,
                                           input logic last);
        t_pin_state s;
        s.rs     = rs;
        s.nibble = nib;
        s.enable = en;
        s.hold   = hold[17:0];
        s.last   = last;
        expected_pins.push_back(s);
    endfunction

    // enable-high then enable-low; extra time lands on the low phase
    function automatic void push_nibble_pulse(input logic rs, input logic [3:0] nib,
                                              input int unsigned extra, input logic last);
        push_pin_state(rs, nib, 1'b1, pulse_ticks, 1'b0);
        push_pin_state(rs, nib, 1'b0, pulse_ticks + extra, last);
    endfunction

    function automatic void push_byte_pulses(input logic rs, input logic [7:0] b,
                                             input int unsigned extra, input logic last);
        push_nibble_pulse(rs, b[7:4], 0, 1'b0);
        push_nibble_pulse(rs, b[3:0], byte_wait_ticks + extra, last);
    endfunction

    function automatic void predict_lcd_pins(input clw_pkg::t_cmd op, input logic [7:0] val);
        case (op)
            clw_pkg::CMD_INIT: begin
                push_pin_state(1'b0, 4'h0, 1'b0, power_on_ticks, 1'b0);
                for (int n = 0; n < 3; n++) begin
                    push_nibble_pulse(1'b0, LCD_WAKE_NIB, busy_ticks, 1'b0);
                end
                push_nibble_pulse(1'b0, LCD_MODE4_NIB, busy_ticks, 1'b0);
                push_byte_pulses(1'b0, LCD_FUNC_SET, 0, 1'b0);
                push_byte_pulses(1'b0, LCD_DISPLAY_ON, 0, 1'b0);
                push_byte_pulses(1'b0, LCD_ENTRY_MODE, 0, 1'b0);
                push_byte_pulses(1'b0, LCD_CLEAR, busy_ticks, 1'b1);
            end
            clw_pkg::CMD_INST: push_byte_pulses(1'b0, val, 0, 1'b1);
            clw_pkg::CMD_DATA: push_byte_pulses(1'b1, val, 0, 1'b1);
            default: ;  // unused code: dropped by the block
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    task automatic send_request(input clw_pkg::t_cmd op, input logic [7:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= op;
        req_if.value <= val;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predict_lcd_pins(op, val);
    endtask

    // stop sending and let every pending pin state come out
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (expected_pins.size() != 0) begin
            @(posedge i_clk);
        end
        // an ignored request leaves nothing to wait on, so allow it to retire
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_timing(input logic [15:0] pulse, input logic [15:0] busy,
                                  input logic [15:0] byte_wait, input logic [15:0] power_on);
        clw_pkg::t_reg_idx regs[4];
        logic [15:0]       vals[4];
        regs = '{clw_pkg::REG_PULSE, clw_pkg::REG_BUSY, clw_pkg::REG_BYTEWAIT,
                 clw_pkg::REG_POWERON};
        vals = '{pulse, busy, byte_wait, power_on};
        wait_for_drain();
        for (int n = 0; n < 4; n++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[n];
            i_cfg_data <= vals[n];
            @(posedge i_clk);
            case (regs[n])
                clw_pkg::REG_PULSE:    pulse_ticks     = vals[n];
                clw_pkg::REG_BUSY:     busy_ticks      = vals[n];
                clw_pkg::REG_BYTEWAIT: byte_wait_ticks = vals[n];
                clw_pkg::REG_POWERON:  power_on_ticks  = vals[n];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_ticks();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return 16'd0;
        end else if (roll < 20) begin
            return 16'd1;
        end else if (roll < 30) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(65535));
    endfunction

    task automatic program_random_timing();
        program_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
    endtask

    task automatic test_reset_timing();
        send_request(clw_pkg::CMD_INIT, 8'h00);
        send_request(clw_pkg::CMD_INST, 8'h00);
        send_request(clw_pkg::CMD_DATA, 8'hFF);
        send_request(clw_pkg::CMD_DATA, 8'hA5);
        send_request(clw_pkg::CMD_INST, 8'h5A);
    endtask

    task automatic test_unused_code();
        send_request(clw_pkg::CMD_NONE, 8'h77);
        send_request(clw_pkg::CMD_NONE, 8'h00);
        send_request(clw_pkg::CMD_DATA, 8'h42);
    endtask

    // RS must drop to command level for the whole init, even right after data
    task automatic test_init_after_data();
        send_request(clw_pkg::CMD_DATA, 8'h01);
        send_request(clw_pkg::CMD_INIT, 8'hC3);
    endtask

    task automatic test_register_extremes();
        program_timing(16'd0, 16'd0, 16'd0, 16'd0);
        send_request(clw_pkg::CMD_INIT, 8'h00);
        send_request(clw_pkg::CMD_DATA, 8'h3C);
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(clw_pkg::CMD_INIT, 8'hFF);
        send_request(clw_pkg::CMD_INST, 8'hFF);
        program_timing(16'd1, 16'd1, 16'd1, 16'd1);
        send_request(clw_pkg::CMD_DATA, 8'h80);
        send_request(clw_pkg::CMD_INST, 8'h7E);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int count);
        int unsigned   roll;
        clw_pkg::t_cmd op;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        program_random_timing();
        for (int n = 0; n < count; n++) begin
            if (n > 0 && n % RETUNE_INTERVAL == 0) begin
                program_random_timing();
            end
            roll = $urandom_range(99);
            if (roll < 8) begin
                op = clw_pkg::CMD_INIT;
            end else if (roll < 14) begin
                op = clw_pkg::CMD_NONE;
            end else if (roll < 55) begin
                op = clw_pkg::CMD_INST;
            end else begin
                op = clw_pkg::CMD_DATA;
            end
            send_request(op, 8'($urandom_range(255)));
        end
    endtask

    // result checker
    initial begin
        t_pin_state got;
        t_pin_state want;
        pin_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pin_if.valid && pin_if.ready) begin
                got.rs     = pin_if.reg_select;
                got.nibble = pin_if.nibble;
                got.enable = pin_if.enable;
                got.hold   = pin_if.hold_ticks;
                got.last   = pin_if.last;
                if (expected_pins.size() == 0) begin
                    flag_error($sformatf({"unexpected pin state rs=%0b nib=%h en=%0b ",
                                          "hold=%0d last=%0b"},
                                         got.rs, got.nibble, got.enable, got.hold,
                                         got.last));
                end else begin
                    want = expected_pins.pop_front();
                    if (got.rs !== want.rs || got.nibble !== want.nibble ||
                        got.enable !== want.enable || got.hold !== want.hold ||
                        got.last !== want.last) begin
                        flag_error($sformatf({"pin state mismatch: exp rs=%0b nib=%h en=%0b ",
                                              "hold=%0d last=%0b, got rs=%0b nib=%h en=%0b ",
                                              "hold=%0d last=%0b"},
                                             want.rs, want.nibble, want.enable, want.hold,
                                             want.last, got.rs, got.nibble, got.enable,
                                             got.hold, got.last));
                    end
                end
            end
            pin_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        mismatch_count  = 0;
        src_idle_pct    = 29;
        snk_idle_pct    = 50;
        pulse_ticks     = 16'd200;
        busy_ticks      = 16'd10000;
        byte_wait_ticks = 16'd16000;
        power_on_ticks  = 16'd50000;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= clw_pkg::REG_PULSE;
        i_cfg_data   <= 16'd0;
        req_if.valid <= 1'b0;
        req_if.cmd   <= clw_pkg::CMD_INIT;
        req_if.value <= 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_timing();
        test_unused_code();
        test_init_after_data();
        test_register_extremes();
        test_random_traffic(29, 50, 150);
        test_random_traffic(50, 29, 150);
        test_random_traffic(0, 0, 150);

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pins.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/clw_pkg.sv
sv/clw_in_if.sv
sv/clw_out_if.sv
sv/clw_ctrl.sv
sv/clw_dp.sv
sv/char_lcd_4bit_writer_core.sv
test/char_lcd_4bit_writer_core_test.sv
